FILE: rtl/lens_undistort_fixed_iter_defines.svh
// Assertion macros shared by the lens undistortion RTL.
// Depends on nothing; included by modules that assert.
`ifndef LENS_UNDISTORT_FIXED_ITER_DEFINES_SVH
`define LENS_UNDISTORT_FIXED_ITER_DEFINES_SVH
`ifndef SYNTHESIS
`define LU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lens undistort check failed");
`define LU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lens undistort check failed");
`else
`define LU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ludist_pkg.sv
// Package for lens undistortion: Q4.27 types, constants and helper functions.
// No dependencies.
`default_nettype none
package ludist_pkg;
    localparam int ITERATIONS = 7;
    localparam int FRAC_BITS  = 27;
    localparam int LIFT_SHIFT = 9;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [31:0] t_q;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FX = 3'd0, REG_INV_FY = 3'd1, REG_OFF_X = 3'd2, REG_OFF_Y = 3'd3,
        REG_K1 = 3'd4, REG_K2 = 3'd5, REG_P1 = 3'd6, REG_P2 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_q k1;
        t_q k2;
        t_q p1;
        t_q p2;
    } t_coefs;

    // iterate state carried between stages
    typedef struct packed {
        t_q mx;
        t_q my;
        t_q x;
        t_q y;
    } t_pt;

    function automatic t_q sat(input logic signed [35:0] v);
        if (v > 36'sd2147483647)       sat = 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648) sat = 32'sh80000000;
        else                           sat = v[31:0];
    endfunction

    // rounded Q4.27 product, saturated
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        logic signed [36:0] s;
        p = a * b;
        s = 37'((p + 64'sd67108864) >>> FRAC_BITS);
        if (s > 37'sd2147483647)       qmul = 32'sh7FFFFFFF;
        else if (s < -37'sd2147483648) qmul = 32'sh80000000;
        else                           qmul = s[31:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/ludist_lift.sv
// Lift stage: pixel times inverse focal plus offset, two register stages.
// Depends on ludist_pkg.
`default_nettype none
module ludist_lift (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [15:0]   i_pix,
    input  wire logic [31:0]   i_inv,
    input  wire ludist_pkg::t_q i_off,
    output logic               o_valid,
    output ludist_pkg::t_q     o_m
);
    logic        r_v1;
    logic [47:0] r_prod;
    logic [47:0] n_prod;
    logic signed [40:0] n_sum;

    assign n_prod = 48'(i_pix) * 48'(i_inv);
    assign n_sum  = 41'((r_prod + 48'd256) >> ludist_pkg::LIFT_SHIFT) + 41'(i_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            if (n_sum > 41'sd2147483647)       o_m <= 32'sh7FFFFFFF;
            else if (n_sum < -41'sd2147483648) o_m <= 32'sh80000000;
            else                               o_m <= n_sum[31:0];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ludist_iter.sv
// One undistortion iteration as a five-stage pipeline, one product per path.
// Depends on ludist_pkg.
`default_nettype none
module ludist_iter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire ludist_pkg::t_pt   i_pt,
    input  wire ludist_pkg::t_coefs i_c,
    output logic                   o_valid,
    output ludist_pkg::t_pt        o_pt
);
    localparam int NST = 5;
    logic [NST-1:0] r_v;
    ludist_pkg::t_pt r_p1, r_p2, r_p3, r_p4;
    ludist_pkg::t_q r_x2, r_y2, r_xy;
    ludist_pkg::t_q r_r2, r_xy2, r_sx, r_sy;
    ludist_pkg::t_q r_r4, r_r2b, r_xy3, r_sx3, r_sy3;
    ludist_pkg::t_q r_rad, r_pxy, r_qxy, r_tx, r_ty;
    ludist_pkg::t_q n_r2;

    assign n_r2 = ludist_pkg::sat(36'(r_x2) + 36'(r_y2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[NST-2:0], i_valid};
    end
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // squares and cross term
            r_p1 <= i_pt;
            r_x2 <= ludist_pkg::qmul(i_pt.x, i_pt.x);
            r_y2 <= ludist_pkg::qmul(i_pt.y, i_pt.y);
            r_xy <= ludist_pkg::qmul(i_pt.x, i_pt.y);
            // r2 and tangential sums
            r_p2  <= r_p1;
            r_r2  <= n_r2;
            r_xy2 <= r_xy;
            r_sx  <= ludist_pkg::sat(36'(n_r2) + 36'(r_x2) + 36'(r_x2));
            r_sy  <= ludist_pkg::sat(36'(n_r2) + 36'(r_y2) + 36'(r_y2));
            // r4
            r_p3  <= r_p2;
            r_r4  <= ludist_pkg::qmul(r_r2, r_r2);
            r_r2b <= r_r2;
            r_xy3 <= r_xy2;
            r_sx3 <= r_sx;
            r_sy3 <= r_sy;
            // radial factor and tangential products
            r_p4  <= r_p3;
            r_rad <= ludist_pkg::sat(36'(ludist_pkg::qmul(i_c.k1, r_r2b))
                     + 36'(ludist_pkg::qmul(i_c.k2, r_r4)));
            r_pxy <= ludist_pkg::qmul(i_c.p1, r_xy3);
            r_qxy <= ludist_pkg::qmul(i_c.p2, r_xy3);
            r_tx  <= ludist_pkg::qmul(i_c.p2, r_sx3);
            r_ty  <= ludist_pkg::qmul(i_c.p1, r_sy3);
            // update
            o_pt.mx <= r_p4.mx;
            o_pt.my <= r_p4.my;
            o_pt.x  <= ludist_pkg::sat(36'(r_p4.mx) - 36'(ludist_pkg::sat(
                       36'(ludist_pkg::qmul(r_rad, r_p4.x)) + 36'(r_pxy)
                       + 36'(r_pxy) + 36'(r_tx))));
            o_pt.y  <= ludist_pkg::sat(36'(r_p4.my) - 36'(ludist_pkg::sat(
                       36'(ludist_pkg::qmul(r_rad, r_p4.y)) + 36'(r_ty)
                       + 36'(r_qxy) + 36'(r_qxy))));
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lens_undistort_fixed_iter.sv
// Lens undistortion top: config registers, lift, iteration chain, output skid.
// Depends on ludist_pkg, ludist_lift, ludist_iter and the defines header.
// Path: the lift registers, the stages of each of the 7 iterations, then the output
// register, from the accepting edge until the word is valid on m_axis.
// Throughput: one word per cycle; s_axis_tready drops only while the skid holds a word.
// Reset: synchronous active low; clears valid bits and config to zero.
`default_nettype none
`include "lens_undistort_fixed_iter_defines.svh"
module lens_undistort_fixed_iter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] pixel_u, [31:16] pixel_v
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [31:0] x_norm, [63:32] y_norm
);
    localparam int N = ludist_pkg::ITERATIONS;

    logic [31:0] r_inv_fx, r_inv_fy;
    ludist_pkg::t_q r_off_x, r_off_y;
    ludist_pkg::t_coefs r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx <= '0; r_inv_fy <= '0; r_off_x <= '0; r_off_y <= '0; r_c <= '0;
        end else if (i_cfg_we) begin
            unique case (ludist_pkg::t_reg_idx'(i_cfg_idx))
                ludist_pkg::REG_INV_FX: r_inv_fx <= i_cfg_data;
                ludist_pkg::REG_INV_FY: r_inv_fy <= i_cfg_data;
                ludist_pkg::REG_OFF_X:  r_off_x  <= i_cfg_data;
                ludist_pkg::REG_OFF_Y:  r_off_y  <= i_cfg_data;
                ludist_pkg::REG_K1:     r_c.k1   <= i_cfg_data;
                ludist_pkg::REG_K2:     r_c.k2   <= i_cfg_data;
                ludist_pkg::REG_P1:     r_c.p1   <= i_cfg_data;
                ludist_pkg::REG_P2:     r_c.p2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipe enable: advance unless the skid is full.
    logic r_out_v, r_skid_v;
    logic [63:0] r_skid_d;
    logic pipe_en;
    logic tail_v;
    ludist_pkg::t_pt tail_pt;

    assign pipe_en       = !r_skid_v;
    assign s_axis_tready = pipe_en;

    logic lx_v, ly_v;
    ludist_pkg::t_q mx, my;

    ludist_lift u_lift_x (.i_clk, .i_rst_n, .i_en(pipe_en),
        .i_valid(s_axis_tvalid), .i_pix(s_axis_tdata[15:0]), .i_inv(r_inv_fx),
        .i_off(r_off_x), .o_valid(lx_v), .o_m(mx));
    ludist_lift u_lift_y (.i_clk, .i_rst_n, .i_en(pipe_en),
        .i_valid(s_axis_tvalid), .i_pix(s_axis_tdata[31:16]), .i_inv(r_inv_fy),
        .i_off(r_off_y), .o_valid(ly_v), .o_m(my));

    logic [N:0] chain_v;
    ludist_pkg::t_pt chain_pt [N+1];
    assign chain_v[0]  = lx_v;
    assign chain_pt[0] = '{mx: mx, my: my, x: mx, y: my};

    for (genvar g = 0; g < N; g++) begin : g_iter
        ludist_iter u_iter (.i_clk, .i_rst_n, .i_en(pipe_en),
            .i_valid(chain_v[g]), .i_pt(chain_pt[g]), .i_c(r_c),
            .o_valid(chain_v[g+1]), .o_pt(chain_pt[g+1]));
    end
    assign tail_v  = chain_v[N];
    assign tail_pt = chain_pt[N];

    // Output register plus skid: the skid catches the pipe's word when the
    // output is stalled, and the pipe stops until it drains.
    logic out_take;
    assign out_take = m_axis_tready || !r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_v  <= r_skid_v || (pipe_en && tail_v);
                r_skid_v <= 1'b0;
            end else if (pipe_en && tail_v) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            m_axis_tdata <= r_skid_v ? r_skid_d : {tail_pt.y, tail_pt.x};
        end else if (pipe_en && tail_v) begin
            r_skid_d <= {tail_pt.y, tail_pt.x};
        end
    end
    assign m_axis_tvalid = r_out_v;

    `LU_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `LU_ASSERT_IMPL(a_lift_pair, i_clk, i_rst_n, 1'b1, lx_v == ly_v)
    `LU_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_v && !m_axis_tready,
        r_out_v && $stable(m_axis_tdata))
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for lens_undistort_fixed_iter: drives pixel words, predicts
// undistorted Q4.27 coordinates and compares them. Depends on ludist_pkg.
`default_nettype none
module testbench;
    localparam int LATENCY   = 38;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 400;
    localparam logic signed [63:0] QMAX = 64'sd2147483647;
    localparam logic signed [63:0] QMIN = -64'sd2147483648;

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
        bit          has_exp;
        logic [31:0] ex;
        logic [31:0] ey;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] pixel_u, [31:16] pixel_v
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // [31:0] x_norm, [63:32] y_norm

    lens_undistort_fixed_iter DUT (.*);

    always #6 i_clk = ~i_clk;

    // shadow copy of the register file
    logic [31:0] inv_fx, inv_fy;
    logic signed [31:0] off_x, off_y, k1, k2, p1, p2;

    logic [63:0] pending_xy[$];
    int  errors = 0;
    int  n_out = 0;
    int  n_in = 0;
    int  idle_cyc = 0;
    int  send_pct = 0;   // percent chance sender idles
    int  recv_pct = 0;   // percent chance receiver stalls

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // Q4.27 product, rounded half up, saturated
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return clamp_q((p + 64'sd67108864) >>> 27);
    endfunction

    function automatic logic signed [63:0] lift_axis(input logic [15:0] pix,
            input logic [31:0] inv, input logic signed [31:0] off);
        logic [63:0] p;
        p = {48'd0, pix} * {32'd0, inv};
        p = (p + 64'd256) >> 9;
        return clamp_q($signed(p) + 64'(off));
    endfunction

    function automatic logic [63:0] undistort(input logic [15:0] u, input logic [15:0] v);
        logic signed [63:0] mx, my, x, y, x2, y2, xy, r2, r4, rad, dx, dy;
        mx = lift_axis(u, inv_fx, off_x);
        my = lift_axis(v, inv_fy, off_y);
        x = mx;
        y = my;
        for (int i = 0; i < ludist_pkg::ITERATIONS; i++) begin
            x2  = fx_mul(x, x);
            y2  = fx_mul(y, y);
            xy  = fx_mul(x, y);
            r2  = clamp_q(x2 + y2);
            r4  = fx_mul(r2, r2);
            rad = clamp_q(fx_mul(64'(k1), r2) + fx_mul(64'(k2), r4));
            dx  = clamp_q(fx_mul(rad, x) + 2 * fx_mul(64'(p1), xy)
                          + fx_mul(64'(p2), clamp_q(r2 + 2 * x2)));
            dy  = clamp_q(fx_mul(rad, y) + fx_mul(64'(p1), clamp_q(r2 + 2 * y2))
                          + 2 * fx_mul(64'(p2), xy));
            x = clamp_q(mx - dx);
            y = clamp_q(my - dy);
        end
        return {y[31:0], x[31:0]};
    endfunction

    // output side: random stall, check at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_out++;
            if (pending_xy.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
            end else begin
                logic [63:0] e;
                e = pending_xy.pop_front();
                if (e[31:0] !== m_axis_tdata[31:0]) begin
                    errors++;
                    $display("%0t: x_norm exp %h got %h", $time, e[31:0], m_axis_tdata[31:0]);
                end
                if (e[63:32] !== m_axis_tdata[63:32]) begin
                    errors++;
                    $display("%0t: y_norm exp %h got %h", $time, e[63:32],
                             m_axis_tdata[63:32]);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end

    // watchdog: cycles with no accepted word on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cyc <= 0;
        else if (i_rst_n && (s_axis_tvalid || pending_xy.size() != 0)) begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(input ludist_pkg::t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            ludist_pkg::REG_INV_FX: inv_fx = val;
            ludist_pkg::REG_INV_FY: inv_fy = val;
            ludist_pkg::REG_OFF_X:  off_x = val;
            ludist_pkg::REG_OFF_Y:  off_y = val;
            ludist_pkg::REG_K1:     k1 = val;
            ludist_pkg::REG_K2:     k2 = val;
            ludist_pkg::REG_P1:     p1 = val;
            ludist_pkg::REG_P2:     p2 = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cfg(input logic [31:0] fx, input logic [31:0] fy,
            input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] c1,
            input logic [31:0] c2, input logic [31:0] c3, input logic [31:0] c4);
        write_reg(ludist_pkg::REG_INV_FX, fx);
        write_reg(ludist_pkg::REG_INV_FY, fy);
        write_reg(ludist_pkg::REG_OFF_X, ox);
        write_reg(ludist_pkg::REG_OFF_Y, oy);
        write_reg(ludist_pkg::REG_K1, c1);
        write_reg(ludist_pkg::REG_K2, c2);
        write_reg(ludist_pkg::REG_P1, c3);
        write_reg(ludist_pkg::REG_P2, c4);
    endtask

    // wait for all results, then let the pipe drain
    task automatic drain;
        while (pending_xy.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Sends one word; valid stays high across back-to-back words.
    task automatic send_pixel(input logic [15:0] u, input logic [15:0] v,
                              input logic [63:0] e);
        while ($urandom_range(99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, u};
        pending_xy.push_back(e);
        n_in++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic stop_send;
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_random(input int n, input bit small_pix);
        logic [15:0] u, v;
        for (int i = 0; i < n; i++) begin
            u = small_pix ? 16'($urandom_range(16'h3FFF)) : 16'($urandom);
            v = small_pix ? 16'($urandom_range(16'h3FFF)) : 16'($urandom);
            send_pixel(u, v, undistort(u, v));
        end
        stop_send();
    endtask

    t_row dir_rows[$];
    logic [63:0] e;

    initial begin
        inv_fx = 0; inv_fy = 0; off_x = 0; off_y = 0;
        k1 = 0; k2 = 0; p1 = 0; p2 = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset everything is zero, so the output is zero
        dir_rows.push_back('{16'hFFFF, 16'hFFFF, 1, 32'h0, 32'h0});
        dir_rows.push_back('{16'h0000, 16'h0000, 1, 32'h0, 32'h0});
        foreach (dir_rows[i]) begin
            e = {dir_rows[i].ey, dir_rows[i].ex};
            send_pixel(dir_rows[i].u, dir_rows[i].v, e);
        end
        stop_send();
        drain();

        // no distortion: result equals the lift; offsets only
        load_cfg(0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0);
        dir_rows = {};
        dir_rows.push_back('{16'h1234, 16'h4321, 1, 32'h7FFFFFFF, 32'h80000000});
        dir_rows.push_back('{16'hFFFF, 16'hFFFF, 0, 0, 0});
        foreach (dir_rows[i]) begin
            e = dir_rows[i].has_exp ? {dir_rows[i].ey, dir_rows[i].ex}
                                    : undistort(dir_rows[i].u, dir_rows[i].v);
            send_pixel(dir_rows[i].u, dir_rows[i].v, e);
        end
        stop_send();
        drain();

        // full-scale focal and pixel: lift saturates at top
        load_cfg(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0);
        dir_rows = {};
        dir_rows.push_back('{16'hFFFF, 16'hFFFF, 1, 32'h7FFFFFFF, 32'h7FFFFFFF});
        dir_rows.push_back('{16'h0001, 16'h8000, 0, 0, 0});
        foreach (dir_rows[i]) begin
            e = dir_rows[i].has_exp ? {dir_rows[i].ey, dir_rows[i].ex}
                                    : undistort(dir_rows[i].u, dir_rows[i].v);
            send_pixel(dir_rows[i].u, dir_rows[i].v, e);
        end
        stop_send();
        drain();

        // extreme coefficients: overflow everywhere, saturated results
        load_cfg(32'h00100000, 32'h00100000, 32'hF0000000, 32'h0C000000,
                 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        for (int i = 0; i < 6; i++) begin
            logic [15:0] u, v;
            u = (i[0]) ? 16'hFFFF : 16'h0000;
            v = (i[1]) ? 16'h0000 : 16'hFFFF;
            send_pixel(u, v, undistort(u, v));
        end
        stop_send();
        drain();

        // random phases with realistic camera settings and random extremes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 81; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 81; end
                default: begin send_pct = 21; recv_pct = 21; end
            endcase
            if (ph < 6)
                // focal ~ 6200..25600 px, small distortion
                load_cfg(32'($urandom_range(32'h00AA0000, 32'h00290000)),
                         32'($urandom_range(32'h00AA0000, 32'h00290000)),
                         -32'($urandom_range(32'h10000000)),
                         -32'($urandom_range(32'h10000000)),
                         32'($signed(32'($urandom_range(32'h08000000))) - 32'sh04000000),
                         32'($signed(32'($urandom_range(32'h02000000))) - 32'sh01000000),
                         32'($signed(32'($urandom_range(32'h00400000))) - 32'sh00200000),
                         32'($signed(32'($urandom_range(32'h00400000))) - 32'sh00200000));
            else
                load_cfg($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            send_random(N_RANDOM / 16, 1'b1);
            send_random(N_RANDOM / 16, 1'b0);
            drain();  // sender holds off until every result has come
        end

        while (pending_xy.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        $display("Covered %0d pixel words, %0d results, 8 register settings plus extremes,",
                 n_in, n_out);
        $display("with sender gaps and receiver stalls in separate and joint phases.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
